// ----- hw/rtl/tgapsd_pkg.sv -----
// tgapsd_pkg: shared types, constants and helper functions of the tga pixel stream decoder
`timescale 1ns / 1ps
package tgapsd_pkg;

   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 32;
   localparam int REPEAT_W     = 8;
   localparam int SIZE_W       = 3;
   localparam int MAP_LEN_W    = 10;
   localparam int FIRST_IDX_W  = 9;
   localparam int PIXELS_W     = 29;
   localparam int ADDR_W       = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 29;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_CNT_W  = 3;
   localparam int PACKET_LEN_W = 7;

   localparam logic [BYTE_W-1:0] RUN_FLAG_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_MASK      = 8'h7F;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RLE_MODE          = 3'd0,
      REG_PIXEL_BYTES       = 3'd1,
      REG_USE_COLORMAP      = 3'd2,
      REG_MAP_LENGTH        = 3'd3,
      REG_MAP_ENTRY_BYTES   = 3'd4,
      REG_FIRST_ENTRY_INDEX = 3'd5,
      REG_TOTAL_PIXELS      = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_MAP    = 2'd0,
      PH_HEADER = 2'd1,
      PH_PIXEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MAP_RANGE = 2'd1,
      ST_CLIPPED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_MAP_WRITE = 2'd0,
      CMD_PIXEL     = 2'd1,
      CMD_LOOKUP    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic                   rle_mode;
      logic [SIZE_W-1:0]      pixel_bytes;
      logic                   use_colormap;
      logic [MAP_LEN_W-1:0]   map_length;
      logic [SIZE_W-1:0]      map_entry_bytes;
      logic [FIRST_IDX_W-1:0] first_entry_index;
      logic [PIXELS_W-1:0]    total_pixels;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [ADDR_W-1:0]      addr;
      logic [WORD_W-1:0]      word;
      logic [REPEAT_W-1:0]    repeat_count;
      logic                   image_done;
      status_type             status;
   } cmd_type;

   function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == 3'd0) begin
         r = 3'd1;
      end else if (v > 3'd4) begin
         r = 3'd4;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] swap02(input logic [WORD_W-1:0] w);
      return {w[31:24], w[7:0], w[15:8], w[23:16]};
   endfunction

endpackage

// ----- hw/rtl/tgapsd_channels.sv -----
// tgapsd channels: stream byte, result and register write interfaces
`timescale 1ns / 1ps
interface tgapsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       frame_start;
   modport source (output valid, stream_byte, frame_start, input ready);
   modport sink (input valid, stream_byte, frame_start, output ready);
endinterface

interface tgapsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word;
   logic [7:0]  repeat_count;
   logic        image_done;
   logic [1:0]  status;
   modport source (output valid, pixel_word, repeat_count, image_done, status, input ready);
   modport sink (input valid, pixel_word, repeat_count, image_done, status, output ready);
endinterface

interface tgapsd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [28:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tgapsd_queue.sv -----
// tgapsd_queue: small command queue between the byte parser and the lookup stage
`timescale 1ns / 1ps
module tgapsd_queue
   import tgapsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/tgapsd_front.sv -----
// tgapsd_front: accepts stream bytes, loads map entries, parses packets and counts pixels
`timescale 1ns / 1ps
module tgapsd_front
   import tgapsd_pkg::*;
#(
   parameter int MAP_ENTRIES = 512,
   parameter int MAX_SIDE    = 16384
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   tgapsd_req_if.sink req,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_data
);

   localparam int CW = $clog2(MAP_ENTRIES + 1);
   localparam logic [63:0] SIDE_SQ = 64'(MAX_SIDE) * 64'(MAX_SIDE);

   phase_type           phase_ff, phase_in;
   logic [CW-1:0]       map_count_ff, map_count_in;
   logic [1:0]          bip_ff, bip_in;
   logic [WORD_W-1:0]   gather_ff, gather_in;
   logic [REPEAT_W-1:0] packet_left_ff, packet_left_in;
   logic                is_run_ff, is_run_in;
   logic [PIXELS_W-1:0] done_ff, done_in;

   logic                accept;
   logic                cmd_valid;
   cmd_type             cmd;
   logic [PIXELS_W-1:0] total;
   logic [31:0]         map_lim;
   logic [SIZE_W-1:0]   map_size, pix_size;

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = accept && cmd_valid;
   assign push_data  = cmd;

   always_comb begin
      if (cfg.total_pixels == '0) begin
         total = PIXELS_W'(1);
      end else if (64'(cfg.total_pixels) > SIDE_SQ) begin
         total = SIDE_SQ[PIXELS_W-1:0];
      end else begin
         total = cfg.total_pixels;
      end
      map_lim  = (32'(cfg.map_length) > 32'(MAP_ENTRIES)) ? 32'(MAP_ENTRIES)
                                                          : 32'(cfg.map_length);
      map_size = size_clamp(cfg.map_entry_bytes);
      pix_size = cfg.use_colormap ? SIZE_W'(1) : size_clamp(cfg.pixel_bytes);
   end

   always_comb begin
      logic [WORD_W-1:0]   shifted;
      logic [31:0]         idx;
      logic                in_range;
      logic [REPEAT_W-1:0] cnt;
      logic [PIXELS_W-1:0] remain;
      logic [REPEAT_W-1:0] rep;
      logic                clip;

      phase_in       = phase_ff;
      map_count_in   = map_count_ff;
      bip_in         = bip_ff;
      gather_in      = gather_ff;
      packet_left_in = packet_left_ff;
      is_run_in      = is_run_ff;
      done_in        = done_ff;
      cmd_valid      = 1'b0;
      cmd            = '0;
      shifted        = '0;
      idx            = '0;
      in_range       = 1'b0;
      cnt            = '0;
      remain         = '0;
      rep            = REPEAT_W'(1);
      clip           = 1'b0;

      if (req.frame_start) begin
         phase_in       = PH_MAP;
         map_count_in   = '0;
         bip_in         = '0;
         gather_in      = '0;
         packet_left_in = '0;
         is_run_in      = 1'b0;
         done_in        = '0;
      end

      if (phase_in == PH_MAP && (!cfg.use_colormap || 32'(map_count_in) >= map_lim)) begin
         phase_in  = cfg.rle_mode ? PH_HEADER : PH_PIXEL;
         bip_in    = '0;
         gather_in = '0;
      end

      shifted = WORD_W'(req.stream_byte) << {bip_in, 3'b000};

      case (phase_in)
         PH_MAP: begin
            gather_in = gather_in | shifted;
            if (({1'b0, bip_in} + 3'd1) >= map_size) begin
               cmd_valid    = 1'b1;
               cmd.kind     = CMD_MAP_WRITE;
               cmd.addr     = ADDR_W'(map_count_in);
               cmd.word     = (map_size >= 3'd3) ? swap02(gather_in) : gather_in;
               map_count_in = map_count_in + 1'b1;
               bip_in       = '0;
               gather_in    = '0;
            end else begin
               bip_in = bip_in + 1'b1;
            end
         end
         PH_HEADER, PH_PIXEL: begin
            if (done_in >= total) begin
               phase_in = PH_DONE;
            end else if (phase_in == PH_HEADER) begin
               is_run_in      = (req.stream_byte & RUN_FLAG_MASK) != '0;
               packet_left_in = REPEAT_W'(req.stream_byte & LEN_MASK) + 1'b1;
               phase_in       = PH_PIXEL;
               bip_in         = '0;
               gather_in      = '0;
            end else begin
               gather_in = gather_in | shifted;
               if (({1'b0, bip_in} + 3'd1) < pix_size) begin
                  bip_in = bip_in + 1'b1;
               end else begin
                  cmd_valid = 1'b1;
                  if (cfg.use_colormap) begin
                     idx      = 32'(gather_in[7:0]) + 32'(cfg.first_entry_index);
                     in_range = (idx < 32'(map_count_in)) && (idx < 32'(MAP_ENTRIES));
                     cmd.kind = in_range ? CMD_LOOKUP : CMD_PIXEL;
                     cmd.addr = ADDR_W'(idx);
                     cmd.word = '0;
                  end else begin
                     cmd.kind = CMD_PIXEL;
                     cmd.word = (pix_size >= 3'd3) ? swap02(gather_in) : gather_in;
                  end
                  bip_in    = '0;
                  gather_in = '0;
                  cnt       = (packet_left_in != '0) ? packet_left_in : REPEAT_W'(1);
                  if (cfg.rle_mode && is_run_in) begin
                     remain = total - done_in;
                     if (PIXELS_W'(cnt) > remain) begin
                        rep  = remain[REPEAT_W-1:0];
                        clip = 1'b1;
                     end else begin
                        rep = cnt;
                     end
                     done_in        = done_in + PIXELS_W'(rep);
                     packet_left_in = '0;
                     phase_in       = PH_HEADER;
                  end else if (cfg.rle_mode) begin
                     packet_left_in = cnt - 1'b1;
                     done_in        = done_in + 1'b1;
                     if (done_in >= total && packet_left_in != '0) begin
                        clip = 1'b1;
                     end
                     if (packet_left_in == '0) begin
                        phase_in = PH_HEADER;
                     end
                  end else begin
                     done_in = done_in + 1'b1;
                  end
                  if (done_in >= total) begin
                     phase_in = PH_DONE;
                  end
                  cmd.repeat_count = rep;
                  cmd.image_done   = done_in >= total;
                  if (cfg.use_colormap && !in_range) begin
                     cmd.status = ST_MAP_RANGE;
                  end else if (clip) begin
                     cmd.status = ST_CLIPPED;
                  end else begin
                     cmd.status = ST_OK;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAP;
         map_count_ff   <= '0;
         bip_ff         <= '0;
         gather_ff      <= '0;
         packet_left_ff <= '0;
         is_run_ff      <= 1'b0;
         done_ff        <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         map_count_ff   <= map_count_in;
         bip_ff         <= bip_in;
         gather_ff      <= gather_in;
         packet_left_ff <= packet_left_in;
         is_run_ff      <= is_run_in;
         done_ff        <= done_in;
      end
   end

endmodule

// ----- hw/rtl/tgapsd_back.sv -----
// tgapsd_back: colour map store, lookup and registered result output
`timescale 1ns / 1ps
module tgapsd_back
   import tgapsd_pkg::*;
#(
   parameter int MAP_ENTRIES = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_data,
   tgapsd_rsp_if.source rsp
);

   localparam int AW = $clog2(MAP_ENTRIES);

   logic [WORD_W-1:0]   map_mem [MAP_ENTRIES];
   logic [WORD_W-1:0]   rd_ff;
   logic                valid_ff;
   logic                lookup_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [REPEAT_W-1:0] rep_ff;
   logic                done_ff;
   status_type          status_ff;
   logic                pop;

   assign pop_ready = !valid_ff || rsp.ready;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (pop && pop_data.kind == CMD_MAP_WRITE) begin
         map_mem[pop_data.addr[AW-1:0]] <= pop_data.word;
      end
      if (pop) begin
         rd_ff <= map_mem[pop_data.addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= pop_data.kind != CMD_MAP_WRITE;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         lookup_ff <= pop_data.kind == CMD_LOOKUP;
         word_ff   <= pop_data.word;
         rep_ff    <= pop_data.repeat_count;
         done_ff   <= pop_data.image_done;
         status_ff <= pop_data.status;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.pixel_word   = lookup_ff ? rd_ff : word_ff;
   assign rsp.repeat_count = rep_ff;
   assign rsp.image_done   = done_ff;
   assign rsp.status       = status_ff;

endmodule

// ----- hw/rtl/tga_pixel_stream_decoder.sv -----
// tga_pixel_stream_decoder: top level of the tga colour map and rle pixel decoder
//
// req_if carries one byte of the colour map or pixel data per item, with
// frame_start marking the first byte of an image. rsp_if carries one item
// per decoded pixel or run packet: pixel word, repeat count, image end and status.
// csr_if writes the decode settings by register index; write only while
// the block is idle. csr_if is always ready.
// Throughput: one byte per cycle while the command queue has room, set by the
// parser register loop in the front; map bytes and packet headers produce no result item.
// The byte completing a pixel passes through the four-entry command queue
// and then the map read and output register of the back end before its
// result is valid.
// When rsp_if stalls, the queue keeps absorbing bytes until it is full,
// then req_if.ready drops. Reset clears the parser, queue and output valid
// and sets the default settings; the map store is undefined until loaded.
`timescale 1ns / 1ps
module tga_pixel_stream_decoder
   import tgapsd_pkg::*;
#(
   parameter int MAP_ENTRIES = 512,
   parameter int MAX_SIDE    = 16384
) (
   input logic clock,
   input logic reset,
   tgapsd_req_if.sink   req_if,
   tgapsd_rsp_if.source rsp_if,
   tgapsd_csr_if.sink   csr_if
);

   cfg_type cfg_ff;
   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    pop_valid, pop_ready;
   cmd_type pop_data;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rle_mode          <= 1'b0;
         cfg_ff.pixel_bytes       <= 3'd3;
         cfg_ff.use_colormap      <= 1'b0;
         cfg_ff.map_length        <= '0;
         cfg_ff.map_entry_bytes   <= 3'd3;
         cfg_ff.first_entry_index <= '0;
         cfg_ff.total_pixels      <= PIXELS_W'(1);
      end else if (csr_if.valid) begin
         case (reg_index_type'(csr_if.index))
            REG_RLE_MODE:          cfg_ff.rle_mode          <= csr_if.data[0];
            REG_PIXEL_BYTES:       cfg_ff.pixel_bytes       <= csr_if.data[SIZE_W-1:0];
            REG_USE_COLORMAP:      cfg_ff.use_colormap      <= csr_if.data[0];
            REG_MAP_LENGTH:        cfg_ff.map_length        <= csr_if.data[MAP_LEN_W-1:0];
            REG_MAP_ENTRY_BYTES:   cfg_ff.map_entry_bytes   <= csr_if.data[SIZE_W-1:0];
            REG_FIRST_ENTRY_INDEX: cfg_ff.first_entry_index <= csr_if.data[FIRST_IDX_W-1:0];
            REG_TOTAL_PIXELS:      cfg_ff.total_pixels      <= csr_if.data[PIXELS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tgapsd_front #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .MAX_SIDE    (MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tgapsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tgapsd_back #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_if)
   );

endmodule
